// ----- rtl/core/arll_pkg.sv -----
// Package for the array linked list engine: field widths, item layouts,
// operation codes and status codes. No dependencies.
package arll_pkg;

  // Field widths of the request and result items.
  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned IDX_W  = 7;

  // Stream data widths, whole bytes.
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 48;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
  localparam logic [OP_W-1:0] OP_READ   = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

// ----- rtl/core/array_linked_list_engine.sv -----
// Array linked list engine: an ordered list of data words kept in a link
// memory and a data memory, with a free list. Depends on arll_pkg.
//
// Channel  Dir  Handshake                    Payload (lowest bit first)
// s_axis   in   s_axis_tvalid/s_axis_tready  operation, position, value
// m_axis   out  m_axis_tvalid/m_axis_tready  status, read_data, found_index,
//                                            element_count
//
// An insert, erase or read walks the link memory from the head to its
// position, and a find walks it until a match or the last element (none on
// an empty list), one synchronous read per visited node; clear and unused
// codes need no walk.
// Reset: asynchronous, active low. It empties the list at once; no memory
// sweep is needed, because nodes above the allocation mark read as their
// reset link. Clear works the same way.
// Stalls: a result waits in the output register while the next item is
// taken; a finished item waits in the engine only while that register is
// still full.
module array_linked_list_engine
  import arll_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Request items.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [2:0] operation, [9:3] position, [41:10] value, [47:42] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // Result items.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [1:0] status, [33:2] read_data, [40:34] found_index,
  // [47:41] element_count
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  // Node numbering: node 0 heads the free list, node CAPACITY+1 heads the
  // used list, nodes 1..CAPACITY carry elements. Only the element nodes live
  // in memory; the two head links are registers.
  localparam int unsigned NW   = $clog2(CAPACITY + 2);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned SW   = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [NW-1:0] USED_HEAD = NW'(CAPACITY + 1);
  localparam logic [NW-1:0] FREE_HEAD = '0;
  localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_INS_LINK,
    S_INS_FIX,
    S_ERS_LINK,
    S_ERS_FIX,
    S_RD_DATA,
    S_FIND,
    S_DONE
  } state_e;

  // Memories, one read port shared by address, one write port each.
  logic [NW-1:0] link_mem [CAPACITY];
  logic [SW-1:0] data_mem [CAPACITY];
  logic [NW-1:0] link_rd_q;
  logic [SW-1:0] data_rd_q;

  logic          lk_we;
  logic [NW-1:0] lk_wnode;
  logic [NW-1:0] lk_wdata;
  logic          dt_we;
  logic [NW-1:0] dt_wnode;
  logic [SW-1:0] dt_wdata;
  logic [AW-1:0] rd_addr;

  // Control and working registers.
  state_e            state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [CMPW-1:0]   pos_q, pos_d;
  logic [SW-1:0]     val_q, val_d;
  logic [CW-1:0]     count_q, count_d;
  logic [NW-1:0]     hw_q, hw_d;
  logic [NW-1:0]     free_head_q, free_head_d;
  logic [NW-1:0]     used_first_q, used_first_d;
  logic [NW-1:0]     prev_q, prev_d;
  logic [NW-1:0]     fetch_q, fetch_d;
  logic [NW-1:0]     nxt_q, nxt_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic [VAL_W-1:0]  res_data_q, res_data_d;
  logic [IDX_W-1:0]  res_found_q, res_found_d;
  logic              m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;

  // Request fields.
  logic [OP_W-1:0]  in_op;
  logic [POS_W-1:0] in_pos;
  logic [VAL_W-1:0] in_val;
  logic [CMPW-1:0]  in_pos_ext;
  logic [CMPW-1:0]  cnt_ext;
  logic [CMPW-1:0]  idx_ext;

  logic [NW-1:0]    link_val;
  logic [VAL_W-1:0] rd_ext;

  assign in_op      = s_axis_tdata[OP_W-1:0];
  assign in_pos     = s_axis_tdata[OP_W+POS_W-1:OP_W];
  assign in_val     = s_axis_tdata[OP_W+POS_W+VAL_W-1:OP_W+POS_W];
  assign in_pos_ext = CMPW'(in_pos);
  assign cnt_ext    = CMPW'(count_q);
  assign idx_ext    = CMPW'(idx_q);

  // Successor of the node fetched in the previous cycle. The heads come
  // from registers; a node above the allocation mark has never been written
  // since reset or clear and reads as its reset link, node + 1.
  always_comb begin
    if (fetch_q == USED_HEAD) begin
      link_val = used_first_q;
    end else if (fetch_q == FREE_HEAD) begin
      link_val = free_head_q;
    end else if (fetch_q > hw_q) begin
      link_val = NW'(fetch_q + 1'b1);
    end else begin
      link_val = link_rd_q;
    end
  end

  always_comb begin
    rd_ext         = '0;
    rd_ext[SW-1:0] = data_rd_q;
  end

  // The memories are always read at the node that will be fetched next.
  assign rd_addr = AW'(fetch_d - 1'b1);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    pos_d        = pos_q;
    val_d        = val_q;
    count_d      = count_q;
    hw_d         = hw_q;
    free_head_d  = free_head_q;
    used_first_d = used_first_q;
    prev_d       = prev_q;
    fetch_d      = fetch_q;
    nxt_d        = nxt_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_found_d  = res_found_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    lk_we        = 1'b0;
    lk_wnode     = prev_q;
    lk_wdata     = link_val;
    dt_we        = 1'b0;
    dt_wnode     = fetch_q;
    dt_wdata     = val_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d         = in_op;
          pos_d        = in_pos_ext;
          val_d        = in_val[SW-1:0];
          res_status_d = ST_OK;
          res_data_d   = '0;
          res_found_d  = '0;
          prev_d       = USED_HEAD;
          fetch_d      = USED_HEAD;
          idx_d        = '0;
          state_d      = S_DONE;
          case (in_op)
            OP_INSERT: begin
              if (in_pos_ext > cnt_ext) begin
                res_status_d = ST_RANGE;
              end else if (count_q == FULL_CNT) begin
                res_status_d = ST_FULL;
              end else begin
                state_d = S_WALK;
              end
            end
            OP_ERASE, OP_READ: begin
              if (in_pos_ext >= cnt_ext) begin
                res_status_d = ST_RANGE;
              end else begin
                state_d = S_WALK;
              end
            end
            OP_FIND: begin
              if (count_q != '0) begin
                fetch_d = used_first_q;
                state_d = S_FIND;
              end
            end
            OP_CLEAR: begin
              count_d      = '0;
              hw_d         = '0;
              free_head_d  = NW'(1);
              used_first_d = FREE_HEAD;
            end
            default: begin
              // Unused codes leave everything as it is.
            end
          endcase
        end
      end

      // prev_q is the node before position idx_q; link_val is its successor.
      S_WALK: begin
        if (idx_ext == pos_q) begin
          case (op_q)
            OP_INSERT: begin
              nxt_d   = link_val;
              fetch_d = free_head_q;
              state_d = S_INS_LINK;
            end
            OP_ERASE: begin
              fetch_d = link_val;
              state_d = S_ERS_LINK;
            end
            default: begin
              fetch_d = link_val;
              state_d = S_RD_DATA;
            end
          endcase
        end else begin
          prev_d  = link_val;
          fetch_d = link_val;
          idx_d   = CW'(idx_q + 1'b1);
        end
      end

      // fetch_q is the node taken from the free list; link_val is the new
      // free head.
      S_INS_LINK: begin
        free_head_d = link_val;
        lk_we       = 1'b1;
        lk_wnode    = fetch_q;
        lk_wdata    = nxt_q;
        dt_we       = 1'b1;
        if (fetch_q > hw_q) begin
          hw_d = fetch_q;
        end
        state_d = S_INS_FIX;
      end

      S_INS_FIX: begin
        if (prev_q == USED_HEAD) begin
          used_first_d = fetch_q;
        end else begin
          lk_we    = 1'b1;
          lk_wnode = prev_q;
          lk_wdata = fetch_q;
        end
        count_d = CW'(count_q + 1'b1);
        state_d = S_DONE;
      end

      // fetch_q is the node being removed; link_val is its successor.
      S_ERS_LINK: begin
        if (prev_q == USED_HEAD) begin
          used_first_d = link_val;
        end else begin
          lk_we    = 1'b1;
          lk_wnode = prev_q;
          lk_wdata = link_val;
        end
        state_d = S_ERS_FIX;
      end

      S_ERS_FIX: begin
        lk_we       = 1'b1;
        lk_wnode    = fetch_q;
        lk_wdata    = free_head_q;
        free_head_d = fetch_q;
        count_d     = CW'(count_q - 1'b1);
        state_d     = S_DONE;
      end

      S_RD_DATA: begin
        res_data_d = rd_ext;
        state_d    = S_DONE;
      end

      // fetch_q is the element at position idx_q.
      S_FIND: begin
        if (data_rd_q == val_q) begin
          res_found_d = IDX_W'(idx_q);
          state_d     = S_DONE;
        end else if (CW'(idx_q + 1'b1) == count_q) begin
          res_found_d = IDX_W'(count_q);
          state_d     = S_DONE;
        end else begin
          fetch_d = link_val;
          idx_d   = CW'(idx_q + 1'b1);
        end
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {IDX_W'(count_q), res_found_q, res_data_q, res_status_q};
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_INSERT;
      pos_q        <= '0;
      val_q        <= '0;
      count_q      <= '0;
      hw_q         <= '0;
      free_head_q  <= NW'(1);
      used_first_q <= FREE_HEAD;
      prev_q       <= USED_HEAD;
      fetch_q      <= USED_HEAD;
      nxt_q        <= '0;
      idx_q        <= '0;
      res_status_q <= ST_OK;
      res_data_q   <= '0;
      res_found_q  <= '0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      pos_q        <= pos_d;
      val_q        <= val_d;
      count_q      <= count_d;
      hw_q         <= hw_d;
      free_head_q  <= free_head_d;
      used_first_q <= used_first_d;
      prev_q       <= prev_d;
      fetch_q      <= fetch_d;
      nxt_q        <= nxt_d;
      idx_q        <= idx_d;
      res_status_q <= res_status_d;
      res_data_q   <= res_data_d;
      res_found_q  <= res_found_d;
      m_valid_q    <= m_valid_d;
      m_data_q     <= m_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lk_we) begin
      link_mem[AW'(lk_wnode - 1'b1)] <= lk_wdata;
    end
    link_rd_q <= link_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (dt_we) begin
      data_mem[AW'(dt_wnode - 1'b1)] <= dt_wdata;
    end
    data_rd_q <= data_mem[rd_addr];
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The free list is empty exactly when the list holds CAPACITY elements,
  // except in S_INS_FIX, between taking a free node and counting it.
  a_full_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_INS_FIX) |->
      ((count_q == FULL_CNT) == (free_head_q == USED_HEAD)))
    else $error("free list and element count disagree");

  // Only nodes that have been allocated get their links rewritten.
  a_link_write_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lk_we |-> (lk_wnode != FREE_HEAD) && (lk_wnode <= hw_d))
    else $error("link write to a node that was never allocated");

  // A search never runs past the end of the list.
  a_find_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND) |-> (idx_q < count_q))
    else $error("find walked past the last element");

  // A walk stops at its position, which lies within the list.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (idx_ext <= pos_q) && (pos_q <= cnt_ext))
    else $error("walk went beyond its position");

  // The element count only changes when an insert or erase completes its update, or on a clear.
  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q) == S_INS_FIX || $past(state_q) == S_ERS_FIX ||
       $past(state_q) == S_IDLE))
    else $error("element count changed outside an update");

endmodule

// ----- tb/tb_array_linked_list_engine.sv -----
// Self-checking testbench for the array linked list engine: directed list edge
// cases, then random grow/shrink/mixed request sequences checked against a
// queue-based list predictor. Depends on arll_pkg and array_linked_list_engine.
module tb_array_linked_list_engine;
  import arll_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned PAD_W        = S_TDATA_W - OP_W - POS_W - VAL_W;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned N_DIRECTED   = 23;
  // Timeout in time units, well above the worst run of about 500 items with
  // their stalls and gaps.
  localparam longint unsigned TIMEOUT_UNITS = 4_000_000;

  // Operation codes the engine ignores.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  read_data;
    logic [IDX_W-1:0]  found_index;
    logic [IDX_W-1:0]  element_count;
  } result_t;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    bit               typed;
    result_t          want;
  } directed_row_t;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_ANY} mix_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Predictor state: the list contents in order, head first.
  logic [VAL_W-1:0] list_words[$];
  result_t          pending_results[$];

  int unsigned errors;
  int unsigned results_checked;
  int unsigned full_hits;
  int unsigned range_hits;
  int unsigned peak_count;
  int unsigned op_counts[8];
  int unsigned burst_left;
  bit          hold_off_req;

  // Directed rows. Rows with the typed flag carry their result; the others
  // are checked against the predictor.
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{OP_READ,      7'd0,   32'h0,        1'b1, '{ST_RANGE, 32'h0,        7'd0, 7'd0}},
    '{OP_ERASE,     7'd0,   32'h0,        1'b1, '{ST_RANGE, 32'h0,        7'd0, 7'd0}},
    '{OP_FIND,      7'd0,   32'hDEADBEEF, 1'b1, '{ST_OK,    32'h0,        7'd0, 7'd0}},
    '{OP_INSERT,    7'd1,   32'h11111111, 1'b1, '{ST_RANGE, 32'h0,        7'd0, 7'd0}},
    '{OP_INSERT,    7'd0,   32'hFFFFFFFF, 1'b1, '{ST_OK,    32'h0,        7'd0, 7'd1}},
    '{OP_INSERT,    7'd1,   32'h00000000, 1'b1, '{ST_OK,    32'h0,        7'd0, 7'd2}},
    '{OP_INSERT,    7'd0,   32'h5A5A5A5A, 1'b1, '{ST_OK,    32'h0,        7'd0, 7'd3}},
    '{OP_READ,      7'd0,   32'h0,        1'b1, '{ST_OK,    32'h5A5A5A5A, 7'd0, 7'd3}},
    '{OP_READ,      7'd2,   32'hFFFFFFFF, 1'b1, '{ST_OK,    32'h0,        7'd0, 7'd3}},
    '{OP_READ,      7'd3,   32'h0,        1'b1, '{ST_RANGE, 32'h0,        7'd0, 7'd3}},
    '{OP_FIND,      7'd0,   32'h00000000, 1'b1, '{ST_OK,    32'h0,        7'd2, 7'd3}},
    '{OP_FIND,      7'd0,   32'h12345678, 1'b1, '{ST_OK,    32'h0,        7'd3, 7'd3}},
    '{OP_INSERT,    7'd127, 32'hA5A5A5A5, 1'b1, '{ST_RANGE, 32'h0,        7'd0, 7'd3}},
    '{OP_INSERT,    7'd1,   32'hFFFFFFFF, 1'b0, '{ST_OK,    32'h0,        7'd0, 7'd0}},
    '{OP_FIND,      7'd127, 32'hFFFFFFFF, 1'b1, '{ST_OK,    32'h0,        7'd1, 7'd4}},
    '{OP_ERASE,     7'd3,   32'h0,        1'b1, '{ST_OK,    32'h0,        7'd0, 7'd3}},
    '{OP_ERASE,     7'd0,   32'h0,        1'b0, '{ST_OK,    32'h0,        7'd0, 7'd0}},
    '{OP_READ,      7'd127, 32'h0,        1'b1, '{ST_RANGE, 32'h0,        7'd0, 7'd2}},
    '{OP_UNUSED_LO, 7'd64,  32'h0,        1'b1, '{ST_OK,    32'h0,        7'd0, 7'd2}},
    '{OP_UNUSED_HI, 7'd127, 32'hFFFFFFFF, 1'b1, '{ST_OK,    32'h0,        7'd0, 7'd2}},
    '{OP_CLEAR,     7'd127, 32'hFFFFFFFF, 1'b1, '{ST_OK,    32'h0,        7'd0, 7'd0}},
    '{OP_READ,      7'd0,   32'h0,        1'b1, '{ST_RANGE, 32'h0,        7'd0, 7'd0}},
    '{OP_INSERT,    7'd0,   32'h00000001, 1'b1, '{ST_OK,    32'h0,        7'd0, 7'd1}}
  };

  array_linked_list_engine #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(VAL_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #TIMEOUT_UNITS;
    $display("tb: failure");
    $finish;
  end

  // Applies one request to the list and returns the result it produces.
  function automatic result_t list_apply(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                         logic [VAL_W-1:0] val);
    result_t r;
    int      count;
    int      i;
    r     = '0;
    count = list_words.size();
    case (op)
      OP_INSERT: begin
        if (pos > count) r.status = ST_RANGE;
        else if (count == CAPACITY) r.status = ST_FULL;
        else list_words.insert(pos, val);
      end
      OP_ERASE: begin
        if (pos >= count) r.status = ST_RANGE;
        else list_words.delete(pos);
      end
      OP_READ: begin
        if (pos >= count) r.status = ST_RANGE;
        else r.read_data = list_words[pos];
      end
      OP_FIND: begin
        // First match wins; no match reports the count.
        r.found_index = IDX_W'(count);
        for (i = count - 1; i >= 0; i--)
          if (list_words[i] == val) r.found_index = IDX_W'(i);
      end
      OP_CLEAR: list_words.delete();
      default: ;
    endcase
    r.element_count = IDX_W'(list_words.size());
    return r;
  endfunction

  // Offers one request in the sender's burst pattern and, once it is taken,
  // queues the result it must produce.
  task automatic send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                              logic [VAL_W-1:0] val, bit typed, result_t want);
    result_t     predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 30);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, val, pos, op};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = list_apply(op, pos, val);
    pending_results.push_back(typed ? want : predicted);
    op_counts[op]++;
    if (predicted.status == ST_FULL) full_hits++;
    if (predicted.status == ST_RANGE) range_hits++;
    if (predicted.element_count > peak_count) peak_count = 32'(predicted.element_count);
  endtask

  // Builds one random request. Positions mostly fall in the live range so
  // that deep lists get built; the rest cover the whole field.
  task automatic random_request(mix_e mix);
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int unsigned      pick;
    int unsigned      count;
    count = list_words.size();
    pick  = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:
        op = (pick < 70) ? OP_INSERT : (pick < 80) ? OP_ERASE : (pick < 90) ? OP_READ : OP_FIND;
      MIX_SHRINK:
        op = (pick < 10) ? OP_INSERT : (pick < 65) ? OP_ERASE : (pick < 82) ? OP_READ : OP_FIND;
      default: begin
        if (pick < 30) op = OP_INSERT;
        else if (pick < 55) op = OP_ERASE;
        else if (pick < 75) op = OP_READ;
        else if (pick < 95) op = OP_FIND;
        else if (pick < 97) op = OP_CLEAR;
        else op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end
    endcase
    pos  = POS_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, count)
                                               : $urandom_range(0, 127));
    // A small value pool makes duplicates, so finds hit and pick the first.
    pick = $urandom_range(0, 99);
    if (op == OP_FIND && count != 0 && pick < 40) val = list_words[$urandom_range(0, count - 1)];
    else if (pick < 70) val = VAL_W'($urandom_range(0, 7));
    else val = $urandom;
    send_request(op, pos, val, 1'b0, '0);
  endtask

  // Result checker: every taken result must match the oldest expectation.
  task automatic compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", VAL_W'(want.status), VAL_W'(m_axis_tdata[1:0]));
        compare_field("read_data", want.read_data, m_axis_tdata[33:2]);
        compare_field("found_index", VAL_W'(want.found_index), VAL_W'(m_axis_tdata[40:34]));
        compare_field("element_count", VAL_W'(want.element_count),
                      VAL_W'(m_axis_tdata[47:41]));
        results_checked++;
      end
    end
  end

  // Receiver: stretches of steady, sparse or random readiness, plus one long
  // hold-off on request so the engine backs up and stalls its input.
  initial begin : result_sink
    int unsigned stretch;
    int unsigned style;
    int unsigned hold_left;
    bit          hold_done;
    stretch   = 0;
    style     = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_off_req && !hold_done) begin
        hold_done     = 1'b1;
        hold_left     = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          style   = $urandom_range(0, 3);
          stretch = $urandom_range(5, 60);
        end
        stretch--;
        case (style)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : request_source
    int unsigned sent;
    int unsigned phase_len;
    int          row;
    mix_e        mix;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    for (row = 0; row < N_DIRECTED; row++)
      send_request(directed_rows[row].op, directed_rows[row].pos, directed_rows[row].val,
                   directed_rows[row].typed, directed_rows[row].want);

    // Fill to capacity, then probe insert on a full store: positions at the
    // count and inside the list report full, positions past it report range.
    while (list_words.size() < CAPACITY)
      send_request(OP_INSERT, POS_W'($urandom_range(0, list_words.size())), $urandom,
                   1'b0, '0);
    send_request(OP_INSERT, POS_W'(CAPACITY), 32'hCAFEF00D, 1'b0, '0);
    send_request(OP_INSERT, 7'd0, 32'h0, 1'b0, '0);
    send_request(OP_INSERT, POS_W'(CAPACITY + 1), 32'h0, 1'b0, '0);
    send_request(OP_INSERT, 7'd127, 32'hFFFFFFFF, 1'b0, '0);
    send_request(OP_READ, POS_W'(CAPACITY - 1), 32'h0, 1'b0, '0);
    send_request(OP_ERASE, POS_W'(CAPACITY - 1), 32'h0, 1'b0, '0);
    send_request(OP_INSERT, POS_W'(CAPACITY - 1), 32'h89ABCDEF, 1'b0, '0);

    hold_off_req = 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mix       = mix_e'($urandom_range(0, 2));
      phase_len = $urandom_range(20, 80);
      if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
      repeat (phase_len) begin
        random_request(mix);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d results: insert %0d, erase %0d, read %0d, find %0d, clear %0d",
             results_checked, op_counts[OP_INSERT], op_counts[OP_ERASE], op_counts[OP_READ],
             op_counts[OP_FIND], op_counts[OP_CLEAR]);
    $display("full rejects %0d, range rejects %0d, peak length %0d, ignored codes %0d",
             full_hits, range_hits, peak_count,
             op_counts[5] + op_counts[6] + op_counts[7]);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/arll_pkg.sv
rtl/core/array_linked_list_engine.sv
tb/tb_array_linked_list_engine.sv
